### design/mvw_pkg.sv
// mvw_pkg: shared types and constants of the masked voxel window point extractor
// holds payload structs, the register map, the config bundle and the back-end states
// no dependencies
`default_nettype none

package mvw_pkg;

  // fixed field widths
  localparam int VOXEL_BITS = 16;
  localparam int WIN_BITS   = 16;
  localparam int POS_W      = 28;
  localparam int GRAY_W     = 8;
  localparam int SPC_W      = 16;
  localparam int SLICE_W    = 10;
  localparam int EXT_W      = 11;
  localparam int MAG_W      = VOXEL_BITS + 1;
  localparam int POS_FRAC   = 8;

  localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

  // divider: one quotient bit per step
  localparam int DIV_STEPS = GRAY_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // register port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_VIEW_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SLICE_INDEX = 3'd1;
  localparam logic [IDX_W-1:0] REG_VOL_WIDTH   = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOL_HEIGHT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_VOL_DEPTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WINDOW_LOW  = 3'd5;
  localparam logic [IDX_W-1:0] REG_WINDOW_HIGH = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPACING     = 3'd7;

  typedef enum logic [1:0] {
    MODE_VOLUME     = 2'd0,
    MODE_TRANSVERSE = 2'd1,
    MODE_FRONTAL    = 2'd2,
    MODE_SAGITTAL   = 2'd3
  } view_mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [VOXEL_BITS-1:0] voxel_value;
    logic                         in_mask;
  } voxel_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [GRAY_W-1:0]       gray;
  } point_t;

  typedef struct packed {
    view_mode_t                 view_mode;
    logic [SLICE_W-1:0]         slice_index;
    logic [EXT_W-1:0]           vol_width;
    logic [EXT_W-1:0]           vol_height;
    logic [EXT_W-1:0]           vol_depth;
    logic signed [WIN_BITS-1:0] window_low;
    logic signed [WIN_BITS-1:0] window_high;
    logic [3*SPC_W-1:0]         voxel_spacing;
  } cfg_t;

  // queued work: positions done, gray still to divide
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [MAG_W-1:0]        num_mag;
    logic [MAG_W-1:0]        den_mag;
  } work_t;

endpackage

`default_nettype wire

### design/mvw_regs.sv
// mvw_regs: configuration register file behind the register port
// depends on mvw_pkg (cfg_t, register map)
`default_nettype none

module mvw_regs
  import mvw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              mode_write
);

  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx    = paddr[ADDR_W-1:3];
  assign wr_en      = psel && penable && pwrite;
  assign mode_write = wr_en && (reg_idx == REG_VIEW_MODE);
  assign pready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_mode     <= MODE_VOLUME;
      cfg.slice_index   <= '0;
      cfg.vol_width     <= 11'd256;
      cfg.vol_height    <= 11'd256;
      cfg.vol_depth     <= 11'd256;
      cfg.window_low    <= '0;
      cfg.window_high   <= 16'sd255;
      cfg.voxel_spacing <= 48'h0100_0100_0100;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VIEW_MODE:   cfg.view_mode     <= view_mode_t'(pwdata[1:0]);
        REG_SLICE_INDEX: cfg.slice_index   <= pwdata[SLICE_W-1:0];
        REG_VOL_WIDTH:   cfg.vol_width     <= pwdata[EXT_W-1:0];
        REG_VOL_HEIGHT:  cfg.vol_height    <= pwdata[EXT_W-1:0];
        REG_VOL_DEPTH:   cfg.vol_depth     <= pwdata[EXT_W-1:0];
        REG_WINDOW_LOW:  cfg.window_low    <= signed'(pwdata[WIN_BITS-1:0]);
        REG_WINDOW_HIGH: cfg.window_high   <= signed'(pwdata[WIN_BITS-1:0]);
        REG_SPACING:     cfg.voxel_spacing <= pwdata[3*SPC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VIEW_MODE:   prdata = DATA_W'(cfg.view_mode);
      REG_SLICE_INDEX: prdata = DATA_W'(cfg.slice_index);
      REG_VOL_WIDTH:   prdata = DATA_W'(cfg.vol_width);
      REG_VOL_HEIGHT:  prdata = DATA_W'(cfg.vol_height);
      REG_VOL_DEPTH:   prdata = DATA_W'(cfg.vol_depth);
      REG_WINDOW_LOW:  prdata = DATA_W'(unsigned'(cfg.window_low));
      REG_WINDOW_HIGH: prdata = DATA_W'(unsigned'(cfg.window_high));
      REG_SPACING:     prdata = DATA_W'(cfg.voxel_spacing);
    endcase
  end

endmodule

`default_nettype wire

### design/mvw_front.sv
// mvw_front: scan counters, position math and gray classification of each voxel
// depends on mvw_pkg (cfg_t, voxel_t, work_t)
`default_nettype none

module mvw_front
  import mvw_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   mode_write,
  input  logic   accept,
  input  voxel_t voxel,
  output logic   q_push,
  output work_t  q_wdata
);

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CO_W   = (CNT_W > SLICE_W) ? CNT_W : SLICE_W;
  localparam int CS_W   = ((CO_W > DIM_W) ? CO_W : DIM_W) + 1;
  localparam int PROD_W = CS_W + SPC_W + 1;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [EXT_W-1:0] ext);
    logic [DIM_W-1:0] res;
    if (ext == '0) begin
      res = DIM_W'(1);
    end else if (32'(ext) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(ext);
    end
    return res;
  endfunction

  function automatic logic wraps(input logic [CNT_W-1:0] cnt, input logic [DIM_W-1:0] dim);
    return (32'(cnt) + 32'd1) >= 32'(dim);
  endfunction

  logic [CNT_W-1:0] inner_count, middle_count, outer_count;
  logic [DIM_W-1:0] dim_w, dim_h, dim_d, in_dim, mid_dim;
  logic [CO_W-1:0]  cx, cy, cz;
  logic signed [CS_W-1:0]   off_x, off_y, off_z;
  logic signed [PROD_W-1:0] mul_x, mul_y, mul_z;
  logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
  logic signed [MAG_W-1:0]  vdiff, wdiff;
  logic inner_wrap, middle_wrap, keep;

  assign dim_w = clamp_dim(cfg.vol_width);
  assign dim_h = clamp_dim(cfg.vol_height);
  assign dim_d = clamp_dim(cfg.vol_depth);

  // scan axes per view mode
  always_comb begin
    unique case (cfg.view_mode)
      MODE_VOLUME: begin
        cx = CO_W'(inner_count);  cy = CO_W'(middle_count); cz = CO_W'(outer_count);
        in_dim = dim_w; mid_dim = dim_h;
      end
      MODE_TRANSVERSE: begin
        cx = CO_W'(inner_count);  cy = CO_W'(middle_count); cz = CO_W'(cfg.slice_index);
        in_dim = dim_w; mid_dim = dim_h;
      end
      MODE_FRONTAL: begin
        cx = CO_W'(inner_count);  cz = CO_W'(middle_count); cy = CO_W'(cfg.slice_index);
        in_dim = dim_w; mid_dim = dim_d;
      end
      MODE_SAGITTAL: begin
        cy = CO_W'(inner_count);  cz = CO_W'(middle_count); cx = CO_W'(cfg.slice_index);
        in_dim = dim_h; mid_dim = dim_d;
      end
    endcase
  end

  // centred offsets
  assign off_x = signed'(CS_W'(cx)) - signed'(CS_W'(dim_w >> 1));
  assign off_y = signed'(CS_W'(cy)) - signed'(CS_W'(dim_h >> 1));
  assign off_z = signed'(CS_W'(cz)) - signed'(CS_W'(dim_d >> 1));

  // slice modes scale by unsigned q8.8 spacing
  assign mul_x = off_x * signed'({1'b0, cfg.voxel_spacing[SPC_W-1:0]});
  assign mul_y = off_y * signed'({1'b0, cfg.voxel_spacing[2*SPC_W-1:SPC_W]});
  assign mul_z = off_z * signed'({1'b0, cfg.voxel_spacing[3*SPC_W-1:2*SPC_W]});

  always_comb begin
    if (cfg.view_mode == MODE_VOLUME) begin
      // y and z swap, z negated, integer offsets
      pos_x = signed'(POS_W'(off_x)) <<< POS_FRAC;
      pos_y = (-signed'(POS_W'(off_z))) <<< POS_FRAC;
      pos_z = signed'(POS_W'(off_y)) <<< POS_FRAC;
    end else begin
      pos_x = POS_W'(mul_x);
      pos_y = POS_W'(mul_y);
      pos_z = POS_W'(mul_z);
    end
  end

  // gray > 0 needs numerator and window of one sign; an empty window passes v > low
  assign vdiff = MAG_W'(voxel.voxel_value) - MAG_W'(cfg.window_low);
  assign wdiff = MAG_W'(cfg.window_high) - MAG_W'(cfg.window_low);

  always_comb begin
    if (wdiff == '0) begin
      keep = vdiff > 0;
    end else begin
      keep = ((vdiff > 0) && (wdiff > 0)) || ((vdiff < 0) && (wdiff < 0));
    end
  end

  assign q_push          = accept && voxel.in_mask && keep && !mode_write;
  assign q_wdata.pos_x   = pos_x;
  assign q_wdata.pos_y   = pos_y;
  assign q_wdata.pos_z   = pos_z;
  assign q_wdata.num_mag = vdiff[MAG_W-1] ? MAG_W'(-vdiff) : MAG_W'(vdiff);
  assign q_wdata.den_mag = wdiff[MAG_W-1] ? MAG_W'(-wdiff) : MAG_W'(wdiff);

  assign inner_wrap  = wraps(inner_count, in_dim);
  assign middle_wrap = wraps(middle_count, mid_dim);

  always_ff @(posedge clk) begin
    if (rst || mode_write) begin
      inner_count  <= '0;
      middle_count <= '0;
      outer_count  <= '0;
    end else if (accept) begin
      if (!inner_wrap) begin
        inner_count <= inner_count + 1'b1;
      end else begin
        inner_count <= '0;
        if (!middle_wrap) begin
          middle_count <= middle_count + 1'b1;
        end else begin
          middle_count <= '0;
          if (cfg.view_mode != MODE_VOLUME || wraps(outer_count, dim_d)) begin
            outer_count <= '0;
          end else begin
            outer_count <= outer_count + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/mvw_fifo.sv
// mvw_fifo: short queue of classified work between front and back
// depends on mvw_pkg (work_t, QUEUE_DEPTH)
`default_nettype none

module mvw_fifo
  import mvw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  output logic  full,
  input  logic  pop,
  output work_t rdata,
  output logic  empty
);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/mvw_back.sv
// mvw_back: bit-serial gray division and the result register
// depends on mvw_pkg (work_t, point_t, back_state_t)
`default_nettype none

module mvw_back
  import mvw_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  work_t  q_rdata,
  output logic   q_pop,
  input  logic   pop,
  output logic   empty,
  output point_t point
);

  back_state_t state, state_next;

  logic signed [POS_W-1:0] wk_x, wk_y, wk_z;
  logic [MAG_W-1:0]        den;
  logic [MAG_W-1:0]        rem;
  logic [MAG_W:0]          rem_sh;
  logic [GRAY_W-1:0]       quo;
  logic [STEP_W-1:0]       step;
  logic                    sat;
  logic                    out_valid;
  logic                    do_load, do_step, out_write;
  logic                    drop, out_free, last_step;

  assign rem_sh    = {rem, 1'b0};
  assign drop      = !sat && (quo == '0);
  assign out_free  = !out_valid || pop;
  assign last_step = sat || (step == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_DIV;
      BK_DIV:  if (last_step) state_next = BK_DONE;
      BK_DONE: if (drop || out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    do_load   = 1'b0;
    do_step   = 1'b0;
    out_write = 1'b0;
    unique case (state)
      BK_IDLE: do_load   = !q_empty;
      BK_DIV:  do_step   = !sat;
      BK_DONE: out_write = !drop && out_free;
      default: ;
    endcase
  end

  assign q_pop = do_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring division of num*256 by den, num below den
  always_ff @(posedge clk) begin
    if (do_load) begin
      wk_x <= q_rdata.pos_x;
      wk_y <= q_rdata.pos_y;
      wk_z <= q_rdata.pos_z;
      den  <= q_rdata.den_mag;
      rem  <= q_rdata.num_mag;
      sat  <= q_rdata.num_mag >= q_rdata.den_mag;
      quo  <= '0;
      step <= '0;
    end else if (do_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem <= MAG_W'(rem_sh - {1'b0, den});
        quo <= {quo[GRAY_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[MAG_W-1:0];
        quo <= {quo[GRAY_W-2:0], 1'b0};
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_write) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) begin
      point.pos_x <= wk_x;
      point.pos_y <= wk_y;
      point.pos_z <= wk_z;
      point.gray  <= sat ? GRAY_MAX : quo;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

### design/masked_voxel_window_point_extract.sv
// masked_voxel_window_point_extract: top level of the masked voxel point extractor
// depends on mvw_pkg, mvw_regs, mvw_front, mvw_fifo, mvw_back
//
// usage
//   voxels enter on a queue-style channel: voxel is taken at a clock edge with push
//   high and full low. every taken voxel advances the internal raster counters
//   (whole volume, or one transverse, frontal or sagittal slice per view_mode).
//   points leave on a queue-style channel: point is valid while empty is low and is
//   taken at an edge with pop high. one transaction in gives zero or one points out;
//   voxels outside the mask or with a gray level of zero give none.
//   voxel input takes one per cycle until the four-entry work queue fills. each
//   point then passes through the back end one at a time: it is taken from the
//   queue, divided by the one-bit-per-cycle gray divider (skipped when gray
//   saturates at 255) and then written to the point register or dropped.
//   a stalled receiver holds the point register; the back end waits with the next
//   finished point and the queue keeps taking voxels until it is full.
//   reset (rst, synchronous) clears the counters, the queue and the point valid flag
//   and loads the register defaults. writing view_mode restarts the scan.
//   registers sit at 8-byte steps on the register port, 64-bit data, pready tied high.
`default_nettype none

module masked_voxel_window_point_extract
  import mvw_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // voxel channel
  input  logic              push,
  output logic              full,
  input  voxel_t            voxel,
  // point channel
  output logic              empty,
  input  logic              pop,
  output point_t            point,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  mode_write;
  logic  accept;
  logic  q_push, q_pop, q_full, q_empty;
  work_t q_wdata, q_rdata;

  // a voxel transaction completes whenever the work queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  mvw_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .mode_write (mode_write)
  );

  // front: counters, positions and the keep/drop decision
  mvw_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .mode_write (mode_write),
    .accept     (accept),
    .voxel      (voxel),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // decouples the one-per-cycle front (held while the queue is full) from the multi-cycle back
  mvw_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: gray division, saturation and the point register
  mvw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .point   (point)
  );

endmodule

`default_nettype wire

### design/mvw_checker.sv
// mvw_checker: port-level checks of the masked voxel point extractor, bound to the top
// depends on mvw_pkg and masked_voxel_window_point_extract
`default_nettype none

module mvw_checker
  import mvw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input point_t            point,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  // no point survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("point channel not empty after reset");

  // dark voxels never leave as points
  a_gray_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (point.gray != '0))
    else $error("point with zero gray");

  // a stalled point stays put
  a_point_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(point)))
    else $error("stalled point changed or vanished");

  // view_mode reads back what was written
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[ADDR_W-1:3] == REG_VIEW_MODE))
    |=> (!psel || pwrite || (paddr[ADDR_W-1:3] != REG_VIEW_MODE)
         || (prdata[1:0] == $past(pwdata[1:0]))))
    else $error("view_mode readback mismatch");

endmodule

bind masked_voxel_window_point_extract mvw_checker u_mvw_checker (.*);

`default_nettype wire
